@@ hdl/breathing_led_pwm_controller_macros.svh @@
// Assertion macros shared by the breathing LED PWM controller RTL.
`ifndef BREATHING_LED_PWM_CONTROLLER_MACROS_SVH
`define BREATHING_LED_PWM_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define BLPWM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blpwm assertion failed");
`define BLPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blpwm assertion failed");
`else
`define BLPWM_ASSERT_SAME(label, ante, cons)
`define BLPWM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/blpwm_pkg.sv @@
// Shared types and constants of the breathing LED PWM controller.
package blpwm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WAIT_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_HI    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY = 3'd4;

  localparam logic [7:0]  DUTY_HI_RST    = 8'd255;
  localparam logic [7:0]  DUTY_LO_RST    = 8'd0;
  localparam logic [7:0]  STEP_SIZE_RST  = 8'd1;
  localparam logic [15:0] HOLD_MS_RST    = 16'd200;
  localparam logic [15:0] STEP_DELAY_RST = 16'd10;

  localparam logic [7:0] PWM_TOP = 8'd254;

  localparam logic [1:0] MODE_STEADY0  = 2'd0;
  localparam logic [1:0] MODE_BREATHE  = 2'd1;

  typedef struct packed {
    logic       led_on;
    logic [1:0] mode_now;
    logic [7:0] duty_now;
  } res_t;

endpackage

@@ hdl/blpwm_core.sv @@
// Tick state, configuration registers and next-state logic of the controller.
`include "breathing_led_pwm_controller_macros.svh"

module blpwm_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [blpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blpwm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             step_en,
  input  logic                             button_pressed,
  input  logic                             ms_strobe,
  output blpwm_pkg::res_t                  res
);

  logic [7:0]  duty_hi;
  logic [7:0]  duty_lo;
  logic [7:0]  step_size;
  logic [15:0] hold_ms;
  logic [15:0] step_delay_ms;

  logic [7:0]                     pwm_counter, pwm_counter_next;
  logic [7:0]                     duty_level, duty_level_next;
  logic                           ramp_down, ramp_down_next;
  logic [1:0]                     mode_reg, mode_reg_next;
  logic                           btn_released;
  logic [blpwm_pkg::WAIT_W-1:0]   wait_ms, wait_ms_next;

  logic                           press_edge;
  logic                           at_limit_cur;
  logic                           at_limit_new;
  logic [blpwm_pkg::WAIT_W-1:0]   wait_entry;
  logic [8:0]                     sum_up;
  logic [8:0]                     floor_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_hi       <= blpwm_pkg::DUTY_HI_RST;
      duty_lo       <= blpwm_pkg::DUTY_LO_RST;
      step_size     <= blpwm_pkg::STEP_SIZE_RST;
      hold_ms       <= blpwm_pkg::HOLD_MS_RST;
      step_delay_ms <= blpwm_pkg::STEP_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blpwm_pkg::REG_DUTY_HI:    duty_hi       <= cfg_data[7:0];
        blpwm_pkg::REG_DUTY_LO:    duty_lo       <= cfg_data[7:0];
        blpwm_pkg::REG_STEP_SIZE:  step_size     <= cfg_data[7:0];
        blpwm_pkg::REG_HOLD_MS:    hold_ms       <= cfg_data;
        blpwm_pkg::REG_STEP_DELAY: step_delay_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    press_edge    = button_pressed && btn_released;
    mode_reg_next = press_edge ? mode_reg + 2'd1 : mode_reg;
    at_limit_cur  = (duty_level == duty_hi) || (duty_level == duty_lo);

    // entering breathing mode restarts the wait from the current level
    if (press_edge && (mode_reg_next == blpwm_pkg::MODE_BREATHE)) begin
      wait_entry = at_limit_cur ? {1'b0, hold_ms} : '0;
    end else begin
      wait_entry = wait_ms;
    end

    sum_up          = {1'b0, duty_level} + {1'b0, step_size};
    floor_dn        = {1'b0, duty_lo} + {1'b0, step_size};
    duty_level_next = duty_level;
    ramp_down_next  = ramp_down;
    wait_ms_next    = wait_entry;
    at_limit_new    = 1'b0;

    if (mode_reg_next == blpwm_pkg::MODE_BREATHE) begin
      if (wait_entry != '0) begin
        if (ms_strobe) begin
          wait_ms_next = wait_entry - 1'b1;
        end
      end else begin
        if (!ramp_down) begin
          if (sum_up >= {1'b0, duty_hi}) begin
            duty_level_next = duty_hi;
            ramp_down_next  = 1'b1;
          end else begin
            duty_level_next = sum_up[7:0];
          end
        end else begin
          if ({1'b0, duty_level} > floor_dn) begin
            duty_level_next = duty_level - step_size;
          end else begin
            duty_level_next = duty_lo;
            ramp_down_next  = 1'b0;
          end
        end
        at_limit_new = (duty_level_next == duty_hi) || (duty_level_next == duty_lo);
        wait_ms_next = {1'b0, step_delay_ms} + (at_limit_new ? {1'b0, hold_ms} : '0);
      end
    end else begin
      duty_level_next = duty_hi;
      wait_ms_next    = '0;
    end

    pwm_counter_next = (pwm_counter == blpwm_pkg::PWM_TOP) ? 8'd0 : pwm_counter + 8'd1;

    res.led_on   = pwm_counter < duty_level_next;
    res.mode_now = mode_reg_next;
    res.duty_now = duty_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_counter  <= '0;
      duty_level   <= blpwm_pkg::DUTY_HI_RST;
      ramp_down    <= 1'b0;
      mode_reg     <= blpwm_pkg::MODE_STEADY0;
      btn_released <= 1'b1;
      wait_ms      <= '0;
    end else if (step_en) begin
      pwm_counter  <= pwm_counter_next;
      duty_level   <= duty_level_next;
      ramp_down    <= ramp_down_next;
      mode_reg     <= mode_reg_next;
      btn_released <= !button_pressed;
      wait_ms      <= wait_ms_next;
    end
  end

  `BLPWM_ASSERT_SAME(a_pwm_range, 1'b1, pwm_counter != 8'd255)
  `BLPWM_ASSERT_SAME(a_wait_idle, mode_reg != blpwm_pkg::MODE_BREATHE, wait_ms == '0)
  `BLPWM_ASSERT_NEXT(a_pwm_adv, step_en,
    pwm_counter == (($past(pwm_counter) == blpwm_pkg::PWM_TOP) ? 8'd0
                    : $past(pwm_counter) + 8'd1))

endmodule

@@ hdl/breathing_led_pwm_controller.sv @@
// Top level of the breathing LED PWM controller.
//
// One input transfer is one PWM tick: button_pressed (level) and ms_strobe
// (one millisecond elapsed). Every tick yields exactly one result transfer with
// led_on, mode_now and duty_now, in order.
// Results are registered into the output register, or the skid register while
// an earlier result waits. The tick logic is one registered pass, so one tick
// per cycle is sustained while in_ready is high; the two-entry result buffer
// lets a tick be taken while an earlier result still waits. in_ready drops only
// while both entries are full, i.e. after the receiver has stalled for two results.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 duty_hi, 1 duty_lo,
// 2 step_size, 3 hold_ms, 4 step_delay_ms) and cfg_data; cfg_ready is always
// high, other indexes are dropped. Write only while idle.
// Reset (rst, synchronous): registers return to their defaults, mode 0,
// duty 255, PWM counter 0, result buffer empty.
`include "breathing_led_pwm_controller_macros.svh"

module breathing_led_pwm_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             button_pressed,
  input  logic                             ms_strobe,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             led_on,
  output logic [1:0]                       mode_now,
  output logic [7:0]                       duty_now,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blpwm_pkg::CFG_DATA_W-1:0] cfg_data
);

  blpwm_pkg::res_t res_new;
  blpwm_pkg::res_t head;
  blpwm_pkg::res_t skid;
  logic            skid_valid;
  logic            push;
  logic            pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  blpwm_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .step_en        (push),
    .button_pressed (button_pressed),
    .ms_strobe      (ms_strobe),
    .res            (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload side of the two-entry buffer
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= res_new;
        end
      end else if (push) begin
        head <= res_new;
      end
    end else if (push) begin
      if (!out_valid) begin
        head <= res_new;
      end else begin
        skid <= res_new;
      end
    end
  end

  assign led_on   = head.led_on;
  assign mode_now = head.mode_now;
  assign duty_now = head.duty_now;

  `BLPWM_ASSERT_SAME(a_skid_behind_head, skid_valid, out_valid)
  `BLPWM_ASSERT_NEXT(a_full_holds, skid_valid && !out_ready, skid_valid && out_valid)
  `BLPWM_ASSERT_NEXT(a_push_shows, push && !out_valid, out_valid)

endmodule

@@ test/testbench.sv @@
// Testbench for breathing_led_pwm_controller: table and random ticks against a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] MODE_STEADY2 = 2'd2;
  localparam logic [1:0] MODE_STEADY3 = 2'd3;
  localparam logic [blpwm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RAND_PHASES = 8;
  localparam int TICKS_PER_PHASE = 188;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DIR_ROWS = 15;

  typedef struct {
    logic       pressed;
    logic       strobe;
    logic       typed;
    logic       led;
    logic [1:0] mode;
    logic [7:0] duty;
  } tick_row_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic                             button_pressed;
  logic                             ms_strobe;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             led_on;
  logic [1:0]                       mode_now;
  logic [7:0]                       duty_now;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [blpwm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [blpwm_pkg::CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the configuration registers
  logic [7:0]  sh_duty_hi;
  logic [7:0]  sh_duty_lo;
  logic [7:0]  sh_step_size;
  logic [15:0] sh_hold_ms;
  logic [15:0] sh_step_delay;

  // predicted block state
  logic [7:0]                   pwm_phase;
  logic [7:0]                   duty_lvl;
  logic                         dimming;
  logic [1:0]                   cur_mode;
  logic                         btn_was_up;
  logic [blpwm_pkg::WAIT_W-1:0] ms_left;

  blpwm_pkg::res_t led_state_q[$];
  int   err_count = 0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   hold_left = 0;
  int   hold_asks = 0;
  int   hold_done = 0;
  int unsigned cycles = 0;

  tick_row_t dir_rows [DIR_ROWS];

  breathing_led_pwm_controller uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .button_pressed (button_pressed),
    .ms_strobe      (ms_strobe),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .led_on         (led_on),
    .mode_now       (mode_now),
    .duty_now       (duty_now),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic at_end(input logic [7:0] d);
    return d == sh_duty_hi || d == sh_duty_lo;
  endfunction

  function automatic void apply_reg(input logic [blpwm_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [blpwm_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      blpwm_pkg::REG_DUTY_HI:    sh_duty_hi = val[7:0];
      blpwm_pkg::REG_DUTY_LO:    sh_duty_lo = val[7:0];
      blpwm_pkg::REG_STEP_SIZE:  sh_step_size = val[7:0];
      blpwm_pkg::REG_HOLD_MS:    sh_hold_ms = val;
      blpwm_pkg::REG_STEP_DELAY: sh_step_delay = val;
      default: ;
    endcase
  endfunction

  // one PWM tick: button edge, mode logic, compare, counter advance
  function automatic blpwm_pkg::res_t next_led_state(input logic pressed, input logic strobe);
    blpwm_pkg::res_t r;
    logic [8:0]      sum;
    if (pressed) begin
      if (btn_was_up) begin
        cur_mode = cur_mode + 2'd1;
        if (cur_mode == blpwm_pkg::MODE_BREATHE)
          ms_left = at_end(duty_lvl) ? {1'b0, sh_hold_ms} : '0;
        else
          duty_lvl = sh_duty_hi;
      end
      btn_was_up = 1'b0;
    end else begin
      btn_was_up = 1'b1;
    end
    if (cur_mode == blpwm_pkg::MODE_BREATHE) begin
      if (ms_left != '0) begin
        if (strobe) ms_left = ms_left - 1'b1;
      end else begin
        if (!dimming) begin
          sum = {1'b0, duty_lvl} + {1'b0, sh_step_size};
          if (sum >= {1'b0, sh_duty_hi}) begin
            duty_lvl = sh_duty_hi;
            dimming = 1'b1;
          end else begin
            duty_lvl = sum[7:0];
          end
        end else if ({1'b0, duty_lvl} > {1'b0, sh_duty_lo} + {1'b0, sh_step_size}) begin
          duty_lvl = duty_lvl - sh_step_size;
        end else begin
          duty_lvl = sh_duty_lo;
          dimming = 1'b0;
        end
        ms_left = {1'b0, sh_step_delay} + (at_end(duty_lvl) ? {1'b0, sh_hold_ms} : '0);
      end
    end else begin
      duty_lvl = sh_duty_hi;
      ms_left = '0;
    end
    r.led_on = pwm_phase < duty_lvl;
    r.mode_now = cur_mode;
    r.duty_now = duty_lvl;
    pwm_phase = (pwm_phase == blpwm_pkg::PWM_TOP) ? 8'd0 : pwm_phase + 8'd1;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input blpwm_pkg::res_t want,
                               input blpwm_pkg::res_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t %s: expected led %0d mode %0d duty %0d, got led %0d mode %0d duty %0d",
               $time, what, want.led_on, want.mode_now, want.duty_now,
               got.led_on, got.mode_now, got.duty_now);
  endtask

  // called at a falling edge, returns at a falling edge with in_valid still high
  task automatic send_tick(input logic pressed, input logic strobe,
                           input logic typed, input blpwm_pkg::res_t typed_res);
    blpwm_pkg::res_t model_res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    button_pressed <= pressed;
    ms_strobe <= strobe;
    do @(posedge clk); while (in_ready !== 1'b1);
    model_res = next_led_state(pressed, strobe);
    led_state_q.push_back(typed ? typed_res : model_res);
    @(negedge clk);
  endtask

  // writes all five registers back to back, plus one write to an unused index
  task automatic set_regs(input logic [7:0] mx, input logic [7:0] mn, input logic [7:0] st,
                          input logic [15:0] hd, input logic [15:0] dl);
    logic [blpwm_pkg::CFG_IDX_W-1:0]  idx [6];
    logic [blpwm_pkg::CFG_DATA_W-1:0] dat [6];
    idx[0] = blpwm_pkg::REG_DUTY_HI;    dat[0] = {8'($urandom_range(255)), mx};
    idx[1] = blpwm_pkg::REG_DUTY_LO;    dat[1] = {8'($urandom_range(255)), mn};
    idx[2] = blpwm_pkg::REG_STEP_SIZE;  dat[2] = {8'($urandom_range(255)), st};
    idx[3] = blpwm_pkg::REG_HOLD_MS;    dat[3] = hd;
    idx[4] = blpwm_pkg::REG_STEP_DELAY; dat[4] = dl;
    idx[5] = REG_UNUSED;                dat[5] = 16'($urandom_range(65535));
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= dat[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      apply_reg(idx[i], dat[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_asks != hold_done) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_done = hold_asks;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    blpwm_pkg::res_t got;
    blpwm_pkg::res_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.led_on = led_on;
      got.mode_now = mode_now;
      got.duty_now = duty_now;
      if (led_state_q.size() == 0) begin
        flag_mismatch("unexpected transfer", '0, got);
      end else begin
        want = led_state_q.pop_front();
        if (want.led_on !== got.led_on || want.mode_now !== got.mode_now ||
            want.duty_now !== got.duty_now)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("breathing_led_pwm_controller: mismatch");
      $finish;
    end
  end

  initial begin
    blpwm_pkg::res_t row_res;
    logic            btn;
    int              flip_pct;
    logic [7:0]      rmax;
    logic [7:0]      rmin;
    rst = 1'b1;
    in_valid = 1'b0;
    button_pressed = 1'b0;
    ms_strobe = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sh_duty_hi = blpwm_pkg::DUTY_HI_RST;
    sh_duty_lo = blpwm_pkg::DUTY_LO_RST;
    sh_step_size = blpwm_pkg::STEP_SIZE_RST;
    sh_hold_ms = blpwm_pkg::HOLD_MS_RST;
    sh_step_delay = blpwm_pkg::STEP_DELAY_RST;
    pwm_phase = '0;
    duty_lvl = 8'd255;
    dimming = 1'b0;
    cur_mode = blpwm_pkg::MODE_STEADY0;
    btn_was_up = 1'b1;
    ms_left = '0;
    btn = 1'b0;

    // reset config: walk all modes, held button, both strobe levels
    dir_rows = '{
      '{1'b0, 1'b0, 1'b1, 1'b1, blpwm_pkg::MODE_STEADY0, 8'd255},
      '{1'b1, 1'b1, 1'b1, 1'b1, blpwm_pkg::MODE_BREATHE, 8'd255},
      '{1'b1, 1'b0, 1'b1, 1'b1, blpwm_pkg::MODE_BREATHE, 8'd255},
      '{1'b0, 1'b1, 1'b1, 1'b1, blpwm_pkg::MODE_BREATHE, 8'd255},
      '{1'b1, 1'b0, 1'b1, 1'b1, MODE_STEADY2, 8'd255},
      '{1'b0, 1'b0, 1'b1, 1'b1, MODE_STEADY2, 8'd255},
      '{1'b1, 1'b1, 1'b1, 1'b1, MODE_STEADY3, 8'd255},
      '{1'b1, 1'b1, 1'b1, 1'b1, MODE_STEADY3, 8'd255},
      '{1'b0, 1'b0, 1'b1, 1'b1, MODE_STEADY3, 8'd255},
      '{1'b1, 1'b0, 1'b1, 1'b1, blpwm_pkg::MODE_STEADY0, 8'd255},
      '{1'b0, 1'b1, 1'b1, 1'b1, blpwm_pkg::MODE_STEADY0, 8'd255},
      '{1'b1, 1'b1, 1'b1, 1'b1, blpwm_pkg::MODE_BREATHE, 8'd255},
      '{1'b0, 1'b1, 1'b0, 1'b0, blpwm_pkg::MODE_STEADY0, 8'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, blpwm_pkg::MODE_STEADY0, 8'd0},
      '{1'b0, 1'b0, 1'b0, 1'b0, blpwm_pkg::MODE_STEADY0, 8'd0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row_res.led_on = dir_rows[i].led;
      row_res.mode_now = dir_rows[i].mode;
      row_res.duty_now = dir_rows[i].duty;
      send_tick(dir_rows[i].pressed, dir_rows[i].strobe, dir_rows[i].typed, row_res);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      // drain before touching the registers
      in_valid <= 1'b0;
      while (led_state_q.size() != 0) @(negedge clk);
      repeat (4) @(negedge clk);
      case (ph)
        0: set_regs(8'd255, 8'd0, 8'd1, 16'd0, 16'd0);
        1: set_regs(8'd200, 8'd40, 8'd7, 16'd3, 16'd1);
        2: set_regs(8'd255, 8'd0, 8'd255, 16'd65535, 16'd65535);
        3: set_regs(8'd30, 8'd255, 8'd5, 16'd2, 16'd0);   // min above max
        4: set_regs(8'd100, 8'd50, 8'd0, 16'd1, 16'd1);   // zero step stalls the ramp
        6: set_regs(8'd0, 8'd0, 8'd1, 16'd0, 16'd0);
        default: begin
          rmax = 8'($urandom_range(255, 40));
          rmin = 8'($urandom_range(rmax - 20));
          set_regs(rmax, rmin, 8'($urandom_range(20, 1)), 16'($urandom_range(5)),
                   16'($urandom_range(3)));
        end
      endcase
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
        default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
      endcase
      if (ph == 4) hold_asks++;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        // linger in breathing mode, cycle quickly through the steady ones
        flip_pct = (cur_mode == blpwm_pkg::MODE_BREATHE) ? 2 : 25;
        if ($urandom_range(99) < flip_pct) btn = ~btn;
        send_tick(btn, $urandom_range(99) < 70, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (led_state_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    err_count += led_state_q.size();
    if (err_count == 0)
      $display("breathing_led_pwm_controller: match");
    else
      $display("breathing_led_pwm_controller: mismatch");
    $finish;
  end

endmodule
